/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers for the RTL
// Empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEVER(label, clk, rst_n, a)
`endif
`endif

/* rtl/core/twd_pkg.sv */
// ----------------------------------------------------------------------------
// twd_pkg: shared types and constants of the tile work dispatcher
// Render and tile status codes, opcodes, sequencer states, config indices, result beat.
// ----------------------------------------------------------------------------
package twd_pkg;

	localparam int MAX_TILES   = 1024;
	localparam int MAX_WORKERS = 16;
	localparam int TIDX_W      = $clog2(MAX_TILES);
	localparam int WID_W       = $clog2(MAX_WORKERS);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_BEGIN = 2'd1,
		OP_STOP  = 2'd2,
		OP_DONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_IDLE        = 2'd0,
		RS_WAIT_RENDER = 2'd1,
		RS_RENDERING   = 2'd2,
		RS_WAIT_STOP   = 2'd3
	} rstate_t;

	typedef enum logic [1:0] {
		TS_WAITING   = 2'd0,
		TS_EXECUTING = 2'd1,
		TS_FINISHED  = 2'd2,
		TS_UNUSED    = 2'd3
	} tstate_t;

	typedef enum logic [1:0] {
		SQ_READY,
		SQ_WALK,
		SQ_REPORT
	} seq_t;

	typedef enum logic [2:0] {
		CFG_IMG_W   = 3'd0,
		CFG_IMG_H   = 3'd1,
		CFG_TILE_W  = 3'd2,
		CFG_TILE_H  = 3'd3,
		CFG_WORKERS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  assigned_worker;
		logic [9:0]  tile_index;
		logic [11:0] tile_x;
		logic [11:0] tile_y;
		logic [9:0]  tile_w;
		logic [9:0]  tile_h;
		logic        film_clear;
		logic        pass_done;
		logic [1:0]  status;
		logic [31:0] pass_number;
		logic        last;
	} res_t;

endpackage

/* rtl/core/tile_work_dispatcher_top.sv */
// ----------------------------------------------------------------------------
// tile_work_dispatcher_top: hands image tiles to render workers
// Walks tile status once per render tick, one tile per cycle unless stalled.
// ----------------------------------------------------------------------------
// Begin, stop and worker-done: the sequencer moves to its report state, which
// loads the status beat into the output register. Tick while rendering: one
// tile status memory read per cycle, held while a dispatch waits on output.
// Next input beat is taken once the status beat is in the output register.
// Reset clears control state only; tile memory needs no clearing pass, as the
// first walk of a render and each walk after a pass read all tiles as waiting.
module tile_work_dispatcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  worker_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  assigned_worker,
	output logic [9:0]  tile_index,
	output logic [11:0] tile_x,
	output logic [11:0] tile_y,
	output logic [9:0]  tile_w,
	output logic [9:0]  tile_h,
	output logic        film_clear,
	output logic        pass_done,
	output logic [1:0]  status,
	output logic [31:0] pass_number,
	output logic        last
);
	import twd_pkg::*;
	`include "assert_macros.svh"

	// configuration, raw
	logic [12:0] img_w_q, img_h_q;
	logic [9:0]  til_w_q, til_h_q;
	logic [4:0]  nw_q;

	// clamped geometry
	logic [12:0] img_w, img_h;
	logic [9:0]  til_w, til_h;
	logic [4:0]  nw;
	logic [MAX_WORKERS-1:0] live;

	seq_t    seq_q, seq_d;
	rstate_t rs_q;
	logic [MAX_WORKERS-1:0] busy_q;
	logic [31:0] pass_q;
	logic        clr_pend_q, walk_clr_q, unfin_q, fc_q, pd_q;

	// walk address stage and data stage
	logic [TIDX_W:0] i_q;
	logic [12:0]     x_q, y_q;
	logic            s2_v;
	logic [TIDX_W-1:0] idx_s2;
	logic [12:0]     x_s2, y_s2;

	logic [1:0] tile_mem [MAX_TILES];
	logic [1:0] rd_q;
	logic       mem_we;
	logic [TIDX_W-1:0] mem_wa;
	logic [1:0] mem_wd;

	logic [TIDX_W-1:0] wtile [MAX_WORKERS];

	res_t out_q;
	logic out_v_q;
	logic out_load;

	logic accept_in, out_free, dispatch, advance, more, issue, walk_end;
	logic done_ok;
	logic [1:0] ts;
	logic [MAX_WORKERS-1:0] freeset;
	logic [WID_W-1:0] wk;
	logic [13:0] y_nx;
	logic [12:0] rem_w, rem_h;
	logic [9:0]  cw, ch;

	always_comb begin
		img_w = (img_w_q == 13'd0) ? 13'd1 : ((img_w_q > 13'd4096) ? 13'd4096 : img_w_q);
		img_h = (img_h_q == 13'd0) ? 13'd1 : ((img_h_q > 13'd4096) ? 13'd4096 : img_h_q);
		til_w = (til_w_q < 10'd16) ? 10'd16 : ((til_w_q > 10'd512) ? 10'd512 : til_w_q);
		til_h = (til_h_q < 10'd16) ? 10'd16 : ((til_h_q > 10'd512) ? 10'd512 : til_h_q);
		nw = (nw_q == 5'd0) ? 5'd1 :
			((nw_q > 5'(MAX_WORKERS)) ? 5'(MAX_WORKERS) : nw_q);
		live = MAX_WORKERS'((17'd1 << nw) - 17'd1);
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (seq_q != SQ_READY);
	assign accept_in = in_valid && (seq_q == SQ_READY);
	assign out_free  = !out_v_q || !out_stall;

	assign freeset = ~busy_q & live;
	always_comb begin
		wk = '0;
		for (int k = 0; k < MAX_WORKERS; k++) begin
			if (freeset[k]) wk = WID_W'(k);
		end
	end

	assign ts       = walk_clr_q ? TS_WAITING : rd_q;
	assign dispatch = s2_v && (ts == TS_WAITING) && (freeset != '0);
	assign advance  = !dispatch || out_free;
	assign more     = (x_q < img_w) && !i_q[TIDX_W];
	assign issue    = (seq_q == SQ_WALK) && advance && more;
	assign walk_end = (seq_q == SQ_WALK) && !s2_v && !more;
	assign y_nx     = {1'b0, y_q} + {4'd0, til_h};

	assign rem_w = img_w - x_s2;
	assign rem_h = img_h - y_s2;
	assign cw = (rem_w < {3'd0, til_w}) ? rem_w[9:0] : til_w;
	assign ch = (rem_h < {3'd0, til_h}) ? rem_h[9:0] : til_h;

	assign done_ok = ({1'b0, worker_id} < nw) && busy_q[worker_id];

	assign out_load = ((seq_q == SQ_WALK) && dispatch && out_free) ||
		((seq_q == SQ_REPORT) && out_free);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s2;
		mem_wd = TS_EXECUTING;
		if (seq_q == SQ_WALK) begin
			// a clearing walk writes back every tile it passes
			mem_we = s2_v && advance && (dispatch || walk_clr_q);
			mem_wd = dispatch ? TS_EXECUTING : TS_WAITING;
		end else if (accept_in && (opcode == OP_DONE) && done_ok) begin
			mem_we = 1'b1;
			mem_wa = wtile[worker_id];
			mem_wd = TS_FINISHED;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) tile_mem[mem_wa] <= mem_wd;
		if (issue) rd_q <= tile_mem[i_q[TIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if ((seq_q == SQ_WALK) && dispatch && out_free) wtile[wk] <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_q <= SQ_READY;
		else seq_q <= seq_d;
	end

	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_READY: begin
				if (accept_in) begin
					if ((opcode == OP_TICK) &&
						((rs_q == RS_RENDERING) || (rs_q == RS_WAIT_RENDER)))
						seq_d = SQ_WALK;
					else
						seq_d = SQ_REPORT;
				end
			end
			SQ_WALK:   if (walk_end) seq_d = SQ_REPORT;
			SQ_REPORT: if (out_free) seq_d = SQ_READY;
			default:   seq_d = SQ_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= 13'd1024;
			img_h_q    <= 13'd1024;
			til_w_q    <= 10'd128;
			til_h_q    <= 10'd128;
			nw_q       <= 5'd16;
			rs_q       <= RS_IDLE;
			busy_q     <= '0;
			pass_q     <= '0;
			clr_pend_q <= 1'b0;
			walk_clr_q <= 1'b0;
			unfin_q    <= 1'b0;
			fc_q       <= 1'b0;
			pd_q       <= 1'b0;
			s2_v       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// geometry only changes while idle
			if (cfg_valid && (rs_q == RS_IDLE)) begin
				unique case (cfg_index)
					CFG_IMG_W:   img_w_q <= cfg_data;
					CFG_IMG_H:   img_h_q <= cfg_data;
					CFG_TILE_W:  til_w_q <= cfg_data[9:0];
					CFG_TILE_H:  til_h_q <= cfg_data[9:0];
					CFG_WORKERS: nw_q    <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (out_free) out_v_q <= out_load;

			unique case (seq_q)
				SQ_READY: begin
					if (accept_in) begin
						fc_q <= (opcode == OP_TICK) && (rs_q == RS_WAIT_RENDER);
						pd_q <= 1'b0;
						unique case (opcode)
							OP_BEGIN: if (rs_q == RS_IDLE) rs_q <= RS_WAIT_RENDER;
							OP_STOP:  if (rs_q == RS_RENDERING) rs_q <= RS_WAIT_STOP;
							OP_DONE:  if (done_ok) busy_q[worker_id] <= 1'b0;
							default: begin
								if (rs_q == RS_WAIT_STOP) begin
									if ((busy_q & live) == '0) rs_q <= RS_IDLE;
								end else if (rs_q != RS_IDLE) begin
									walk_clr_q <= clr_pend_q || (rs_q == RS_WAIT_RENDER);
									clr_pend_q <= 1'b0;
									if (rs_q == RS_WAIT_RENDER) rs_q <= RS_RENDERING;
									unfin_q <= 1'b0;
									i_q     <= '0;
									x_q     <= '0;
									y_q     <= '0;
									s2_v    <= 1'b0;
								end
							end
						endcase
					end
				end
				SQ_WALK: begin
					if (advance) begin
						s2_v <= issue;
						if (s2_v && (ts != TS_FINISHED)) unfin_q <= 1'b1;
					end
					if (issue) begin
						idx_s2 <= i_q[TIDX_W-1:0];
						x_s2   <= x_q;
						y_s2   <= y_q;
						i_q    <= i_q + 1'b1;
						// column-major: row is the inner loop
						if (y_nx >= {1'b0, img_h}) begin
							y_q <= '0;
							x_q <= x_q + {3'd0, til_w};
						end else begin
							y_q <= y_nx[12:0];
						end
					end
					if (dispatch && out_free) begin
						busy_q[wk] <= 1'b1;
						out_q   <= '{kind: 1'b0, assigned_worker: 4'(wk),
							tile_index: 10'(idx_s2), tile_x: x_s2[11:0],
							tile_y: y_s2[11:0], tile_w: cw, tile_h: ch,
							film_clear: 1'b0, pass_done: 1'b0, status: 2'd0,
							pass_number: 32'd0, last: 1'b0};
					end
					if (walk_end && !unfin_q) begin
						pd_q       <= 1'b1;
						pass_q     <= pass_q + 32'd1;
						clr_pend_q <= 1'b1;
					end
				end
				SQ_REPORT: begin
					if (out_free) begin
						out_q   <= '{kind: 1'b1, assigned_worker: 4'd0,
							tile_index: 10'd0, tile_x: 12'd0, tile_y: 12'd0,
							tile_w: 10'd0, tile_h: 10'd0, film_clear: fc_q,
							pass_done: pd_q, status: rs_q, pass_number: pass_q,
							last: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid       = out_v_q;
	assign kind            = out_q.kind;
	assign assigned_worker = out_q.assigned_worker;
	assign tile_index      = out_q.tile_index;
	assign tile_x          = out_q.tile_x;
	assign tile_y          = out_q.tile_y;
	assign tile_w          = out_q.tile_w;
	assign tile_h          = out_q.tile_h;
	assign film_clear      = out_q.film_clear;
	assign pass_done       = out_q.pass_done;
	assign status          = out_q.status;
	assign pass_number     = out_q.pass_number;
	assign last            = out_q.last;

	`ASSERT_IMPLY(a_walk_rendering, clk, arst_n, seq_q == SQ_WALK, rs_q == RS_RENDERING)
	`ASSERT_IMPLY(a_s2_in_walk, clk, arst_n, s2_v, seq_q == SQ_WALK)
	`ASSERT_IMPLY(a_idle_no_busy, clk, arst_n, rs_q == RS_IDLE, busy_q == '0)

endmodule
